>>> sv/vifs_pkg.sv
// shared types and constants of the interior frame selector
`timescale 1ns / 1ps
package vifs_pkg;

    // fixed field widths
    localparam int TAG_W       = 32;
    localparam int IDX_W       = 16;
    localparam int PAD_CFG_W   = 7;

    // configuration port geometry
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // register index, taken from the word address bit of paddr
    typedef enum logic [0:0] {
        REG_SELECT_UNVOICED = 1'b0,
        REG_PADDING_FRAMES  = 1'b1
    } t_reg_idx;

    // live configuration handed to the datapath
    typedef struct packed {
        logic                 select_unvoiced;
        logic [PAD_CFG_W-1:0] padding_frames;
    } t_cfg;

endpackage

>>> sv/vifs_frame_if.sv
// input frame channel
`timescale 1ns / 1ps
interface vifs_frame_if;
    import vifs_pkg::*;

    logic             valid;
    logic             ready;
    logic             voiced;
    logic [TAG_W-1:0] frame_tag;
    logic             utterance_end;

    modport source (output valid, output voiced, output frame_tag, output utterance_end,
                    input ready);
    modport sink   (input valid, input voiced, input frame_tag, input utterance_end,
                    output ready);
endinterface

>>> sv/vifs_sel_if.sv
// selected frame channel
`timescale 1ns / 1ps
interface vifs_sel_if;
    import vifs_pkg::*;

    logic             valid;
    logic             ready;
    logic [TAG_W-1:0] selected_tag;
    logic [IDX_W-1:0] source_index;

    modport source (output valid, output selected_tag, output source_index, input ready);
    modport sink   (input valid, input selected_tag, input source_index, output ready);
endinterface

>>> sv/vifs_cfg_regs.sv
// apb configuration registers of the interior frame selector
`timescale 1ns / 1ps
module vifs_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vifs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [vifs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [vifs_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output vifs_pkg::t_cfg                o_cfg
);
    import vifs_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    // register write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SELECT_UNVOICED: r_cfg.select_unvoiced <= pwdata[0];
                REG_PADDING_FRAMES:  r_cfg.padding_frames  <= pwdata[PAD_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_SELECT_UNVOICED: prdata = {{(APB_DATA_W-1){1'b0}}, r_cfg.select_unvoiced};
            REG_PADDING_FRAMES:  prdata = {{(APB_DATA_W-PAD_CFG_W){1'b0}},
                                           r_cfg.padding_frames};
            default:             prdata = '0;
        endcase
    end

endmodule

>>> sv/vifs_delay_line.sv
// circular tag delay line with one write and one registered read per transfer
`timescale 1ns / 1ps
module vifs_delay_line #(
    parameter int DEPTH = 64,
    parameter int PW    = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [vifs_pkg::TAG_W-1:0]  i_tag,
    input  logic [PW-1:0]               i_dist,
    output logic [vifs_pkg::TAG_W-1:0]  o_tag
);
    import vifs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = ((AW > PW) ? AW : PW) + 2;

    logic [TAG_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [TAG_W-1:0] r_rd_data;
    logic [SW-1:0]    back_sum;
    logic [SW-1:0]    back_mod;
    logic [AW-1:0]    rd_addr;

    // read address is the write pointer moved back by the distance, modulo depth
    always_comb begin
        back_sum = SW'(r_wr) + SW'(DEPTH) - SW'(i_dist);
        back_mod = (back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum;
        rd_addr  = back_mod[AW-1:0];
    end

    // write pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
        end else if (i_push) begin
            r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
    end

    // storage, read sees the old word when both ports hit the same entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tag;
            r_rd_data   <= r_mem[rd_addr];
        end
    end

    assign o_tag = r_rd_data;

endmodule

>>> sv/vad_interior_frame_selector_core.sv
// Interior frame selector: keeps frames lying more than padding frames inside a selected run.
// A selected frame passes from its emitting transfer through stage one and the output register to o_sel.
// Throughput: one frame per cycle while o_sel takes its frames, set by one delay-line write and read per transfer.
// Stalls on o_sel back up through a two-entry pipeline before i_frame.ready drops.
// Reset (synchronous, active low) clears run state, frame count, pointer and registers;
// the delay line itself is not cleared.
`timescale 1ns / 1ps
module vad_interior_frame_selector_core #(
    parameter int MAX_PADDING = 64,
    parameter int MAX_FRAMES  = 65536
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    vifs_frame_if.sink                      i_frame,
    vifs_sel_if.source                      o_sel,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vifs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [vifs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [vifs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import vifs_pkg::*;

    localparam int PW    = $clog2(MAX_PADDING + 1);
    localparam int LW    = $clog2(2 * MAX_PADDING + 2);
    localparam int CAP   = 2 * MAX_PADDING + 1;
    localparam int FC_W  = $clog2(MAX_FRAMES);
    localparam int DW    = ((FC_W > PW) ? FC_W : PW) + 1;

    t_cfg              cfg;
    logic              accept;
    logic              in_ready;
    logic              s1_go;
    logic              pad_sat;
    logic [PW-1:0]     pad;
    logic [LW-1:0]     thr;
    logic [LW-1:0]     n_run_len;
    logic              emit;
    logic [DW-1:0]     pos_diff;
    logic [DW-1:0]     pos_wrap;
    logic [FC_W-1:0]   pos;
    logic [FC_W+IDX_W-1:0] pos_ext;
    logic [TAG_W-1:0]  line_tag;

    logic              r_run_voiced;
    logic [LW-1:0]     r_run_len;
    logic [FC_W-1:0]   r_frame_cnt;
    logic              r_s1_valid;
    logic              r_s1_pzero;
    logic [TAG_W-1:0]  r_s1_tag;
    logic [IDX_W-1:0]  r_s1_idx;
    logic              r_out_valid;
    logic [TAG_W-1:0]  r_out_tag;
    logic [IDX_W-1:0]  r_out_idx;

    vifs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vifs_delay_line #(
        .DEPTH (MAX_PADDING),
        .PW    (PW)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_tag   (i_frame.frame_tag),
        .i_dist  (pad),
        .o_tag   (line_tag)
    );

    // handshake: stage one drains into the output register whenever that is free
    assign s1_go          = r_s1_valid && (!r_out_valid || o_sel.ready);
    assign in_ready       = !r_s1_valid || s1_go;
    assign i_frame.ready  = in_ready;
    assign accept         = i_frame.valid && in_ready;

    // padding clamped to the delay line depth
    always_comb begin
        pad_sat = {{(32-PAD_CFG_W){1'b0}}, cfg.padding_frames} > 32'(MAX_PADDING);
        pad     = pad_sat ? PW'(MAX_PADDING) : PW'(cfg.padding_frames);
        thr     = {pad, 1'b1};
    end

    // run length update and emit decision
    always_comb begin
        if (i_frame.voiced != r_run_voiced) begin
            n_run_len = LW'(1);
        end else if (r_run_len < LW'(CAP)) begin
            n_run_len = r_run_len + 1'b1;
        end else begin
            n_run_len = r_run_len;
        end
        emit = (i_frame.voiced != cfg.select_unvoiced) && (n_run_len >= thr);
    end

    // position of the emitted frame, counter minus padding modulo frame count
    always_comb begin
        pos_diff = DW'(r_frame_cnt) - DW'(pad);
        pos_wrap = pos_diff[DW-1] ? pos_diff + DW'(MAX_FRAMES) : pos_diff;
        pos      = pos_wrap[FC_W-1:0];
        pos_ext  = {{IDX_W{1'b0}}, pos};
    end

    // run state and frame counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_voiced <= 1'b0;
            r_run_len    <= '0;
            r_frame_cnt  <= '0;
        end else if (accept) begin
            if (i_frame.utterance_end) begin
                r_run_voiced <= 1'b0;
                r_run_len    <= '0;
                r_frame_cnt  <= '0;
            end else begin
                r_run_voiced <= i_frame.voiced;
                r_run_len    <= n_run_len;
                r_frame_cnt  <= (r_frame_cnt == FC_W'(MAX_FRAMES - 1)) ? '0
                                                                      : r_frame_cnt + 1'b1;
            end
        end
    end

    // stage one: waits for the delay line read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= emit;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pzero <= (pad == '0);
            r_s1_tag   <= i_frame.frame_tag;
            r_s1_idx   <= pos_ext[IDX_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (o_sel.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_tag <= r_s1_pzero ? r_s1_tag : line_tag;
            r_out_idx <= r_s1_idx;
        end
    end

    assign o_sel.valid        = r_out_valid;
    assign o_sel.selected_tag = r_out_tag;
    assign o_sel.source_index = r_out_idx;

endmodule

>>> test/vad_interior_frame_selector_core_tb.sv
// self-checking testbench of the interior frame selector core
`timescale 1ns / 1ps
module vad_interior_frame_selector_core_tb;
    import vifs_pkg::*;

    localparam int MAX_PAD   = 64;
    localparam int RUN_CAP   = 2 * MAX_PAD + 1;

    // one selected frame as it leaves the block
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [IDX_W-1:0] index;
    } t_sel_frame;

    // predicts selected frames from accepted frames and checks the output stream
    class frame_selector_scoreboard;
        logic [TAG_W-1:0]     tag_line [MAX_PAD];
        int unsigned          wr_ptr;
        logic                 run_voiced;
        int unsigned          run_len;
        logic [IDX_W-1:0]     frame_pos;
        logic                 sel_unvoiced;
        logic [PAD_CFG_W-1:0] pad;
        t_sel_frame           pending [$];
        int                   errors;
        int                   frames_noted;
        int                   results_checked;

        function new();
            wr_ptr          = 0;
            run_voiced      = 1'b0;
            run_len         = 0;
            frame_pos       = '0;
            sel_unvoiced    = 1'b0;
            pad             = '0;
            errors          = 0;
            frames_noted    = 0;
            results_checked = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_SELECT_UNVOICED: sel_unvoiced = value[0];
                REG_PADDING_FRAMES:  pad = value[PAD_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        // run tracking, delay-line read and write for one accepted frame
        function void note_frame(logic v, logic [TAG_W-1:0] tag, logic last);
            int unsigned p;
            t_sel_frame  want;
            p = (pad > MAX_PAD) ? MAX_PAD : pad;
            if (v != run_voiced) begin
                run_voiced = v;
                run_len    = 1;
            end else if (run_len < RUN_CAP) begin
                run_len++;
            end
            if (run_voiced != sel_unvoiced && run_len >= 2 * p + 1) begin
                want.tag   = (p == 0) ? tag : tag_line[(wr_ptr + MAX_PAD - p) % MAX_PAD];
                want.index = frame_pos - IDX_W'(p);
                pending.push_back(want);
            end
            tag_line[wr_ptr] = tag;
            wr_ptr = (wr_ptr + 1) % MAX_PAD;
            if (last) begin
                run_voiced = 1'b0;
                run_len    = 0;
                frame_pos  = '0;
            end else begin
                frame_pos++;
            end
            frames_noted++;
        endfunction

        function void check_result(logic [TAG_W-1:0] tag, logic [IDX_W-1:0] idx);
            t_sel_frame want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected selected frame, actual tag %h index %0d",
                         $time, tag, idx);
                return;
            end
            want = pending.pop_front();
            if (tag !== want.tag) begin
                errors++;
                $display("%0t: selected_tag mismatch, expected %h actual %h",
                         $time, want.tag, tag);
            end
            if (idx !== want.index) begin
                errors++;
                $display("%0t: source_index mismatch, expected %0d actual %0d",
                         $time, want.index, idx);
            end
            results_checked++;
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    vifs_frame_if frame_bus ();
    vifs_sel_if   sel_bus ();

    frame_selector_scoreboard sel_board;
    int idle_pct;
    int stall_pct;
    int settings_used;

    vad_interior_frame_selector_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame_bus),
        .o_sel   (sel_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // receiver side stalls
    initial begin
        sel_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            sel_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && sel_bus.valid && sel_bus.ready) begin
            sel_board.check_result(sel_bus.selected_tag, sel_bus.source_index);
        end
    end

    // register write, then read back the stored value
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] stored;
        stored = (idx == REG_SELECT_UNVOICED) ? {31'b0, value[0]}
                                              : {25'b0, value[PAD_CFG_W-1:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sel_board.set_reg(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== stored) begin
            sel_board.errors++;
            $display("%0t: register %s read back, expected %h actual %h",
                     $time, idx.name(), stored, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one frame transfer, with a random idle gap ahead of it
    task automatic send_frame(input logic v, input logic [TAG_W-1:0] tag, input logic last);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            frame_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        frame_bus.valid         <= 1'b1;
        frame_bus.voiced        <= v;
        frame_bus.frame_tag     <= tag;
        frame_bus.utterance_end <= last;
        do @(posedge i_clk); while (!frame_bus.ready);
        sel_board.note_frame(v, tag, last);
    endtask

    // wait until every predicted frame has come out and the pipeline is empty
    task automatic drain_block();
        frame_bus.valid <= 1'b0;
        while (sel_board.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // runs of random length around the selection threshold, some noisy, some ending
    // the utterance
    task automatic send_random_stream(input int n_frames, input int pad_use);
        int sent;
        int run_len;
        bit run_flag;
        bit noisy;
        bit closes;
        sent     = 0;
        run_flag = 1'b0;
        while (sent < n_frames) begin
            if ($urandom_range(4) != 0) run_flag = ~run_flag;
            noisy = ($urandom_range(9) == 0);
            if ($urandom_range(3) == 0) run_len = $urandom_range(2 * pad_use + 1, 1);
            else run_len = $urandom_range(2 * pad_use + 8, 2 * pad_use + 1);
            closes = ($urandom_range(3) == 0);
            for (int i = 0; i < run_len && sent < n_frames; i++) begin
                send_frame(noisy ? 1'($urandom_range(1)) : run_flag, $urandom(),
                           closes && (i == run_len - 1));
                sent++;
            end
        end
    endtask

    task automatic run_phase(input logic sel_u, input logic [PAD_CFG_W-1:0] pad,
                             input int idle, input int stall, input int n_frames);
        drain_block();
        idle_pct  = idle;
        stall_pct = stall;
        write_reg(REG_SELECT_UNVOICED, {31'b0, sel_u});
        write_reg(REG_PADDING_FRAMES, {25'b0, pad});
        send_random_stream(n_frames, (pad > MAX_PAD) ? MAX_PAD : pad);
        settings_used++;
    endtask

    // run limit
    initial begin
        #12_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        sel_board     = new();
        idle_pct      = 0;
        stall_pct     = 0;
        settings_used = 0;
        i_rst_n                 <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        frame_bus.valid         <= 1'b0;
        frame_bus.voiced        <= 1'b0;
        frame_bus.frame_tag     <= '0;
        frame_bus.utterance_end <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero padding, voiced selected, utterance opening voiced
        write_reg(REG_SELECT_UNVOICED, 32'd0);
        write_reg(REG_PADDING_FRAMES, 32'd0);
        send_frame(1'b1, 32'hFFFF_FFFF, 1'b0);
        send_frame(1'b1, 32'h0000_0000, 1'b0);
        send_frame(1'b0, 32'hA5A5_A5A5, 1'b0);
        send_frame(1'b1, 32'h5A5A_5A5A, 1'b1);
        settings_used++;

        // padding of one, unvoiced selected, edges of each run dropped
        drain_block();
        write_reg(REG_SELECT_UNVOICED, 32'd1);
        write_reg(REG_PADDING_FRAMES, 32'd1);
        send_frame(1'b0, 32'h1111_1111, 1'b0);
        send_frame(1'b0, 32'h2222_2222, 1'b0);
        send_frame(1'b0, 32'h3333_3333, 1'b0);
        send_frame(1'b0, 32'h4444_4444, 1'b0);
        send_frame(1'b1, 32'h8000_0001, 1'b0);
        send_frame(1'b1, 32'h7FFF_FFFE, 1'b0);
        send_frame(1'b1, 32'hDEAD_BEEF, 1'b0);
        send_frame(1'b0, 32'h0F0F_0F0F, 1'b0);
        send_frame(1'b0, 32'hF0F0_F0F0, 1'b0);
        send_frame(1'b0, 32'h1234_5678, 1'b1);
        settings_used++;

        // random phases; utterances may stay open across a register change
        run_phase(1'b0, 7'd1,   0,  0,  80);
        run_phase(1'b1, 7'd2,   87, 0,  80);
        run_phase(1'b0, 7'd0,   0,  87, 70);
        run_phase(1'b1, 7'd5,   17, 17, 80);
        run_phase(1'b0, 7'd64,  0,  17, 170);
        run_phase(1'b1, 7'd127, 17, 0,  170);

        drain_block();
        repeat (8) @(posedge i_clk);
        $display("covered %0d frames under %0d register settings, %0d selected frames checked",
                 sel_board.frames_noted, settings_used, sel_board.results_checked);
        $display("including both run kinds, stalls on either side and saturated padding");
        if (sel_board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
sv/vifs_pkg.sv
sv/vifs_frame_if.sv
sv/vifs_sel_if.sv
sv/vifs_cfg_regs.sv
sv/vifs_delay_line.sv
sv/vad_interior_frame_selector_core.sv
test/vad_interior_frame_selector_core_tb.sv
